// ===== hw/rtl/f32mm_pkg.sv =====
// Shared types, constants and helpers for the binary32 row matrix multiplier.
`default_nettype none
package f32mm_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NACC      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS  = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_A    = 1'b1;

  localparam logic [6:0] INNER_LEN_RST = 7'd16;
  localparam logic [4:0] OUT_COLS_RST  = 5'd16;

  localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [31:0] INF32  = 32'h7F80_0000;

  typedef struct packed {
    logic take;
    logic start;
    logic issue;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic item_valid;
    logic a_hit;
    logic issue_last;
    logic row_end;
    logic pipe_busy;
    logic out_free;
    logic emit_last;
  } sts_t;

  // position of the highest set bit, 0 for a zero word
  function automatic logic [5:0] lead64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/f32mm_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface f32mm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  k_index;
  logic [3:0]  col_index;
  logic [31:0] elem_bits;
  modport source (output valid, opcode, k_index, col_index, elem_bits, input ready);
  modport sink   (input valid, opcode, k_index, col_index, elem_bits, output ready);
endinterface

interface f32mm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_col;
  logic [31:0] product_bits;
  logic        row_last;
  modport source (output valid, out_col, product_bits, row_last, input ready);
  modport sink   (input valid, out_col, product_bits, row_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/f32_matrix_multiply_rows.sv =====
// Top level: streaming binary32 C = A*B, one output row at a time.
//
//   channel  dir  payload                                   transfer when
//   item     in   opcode, k_index, col_index, elem_bits     valid && ready
//   result   out  out_col, product_bits, row_last           valid && ready
//   cfg      in   cfg_idx, cfg_data                         cfg_we
//
// A B load writes the B store when accepted and in range. For an A element
// within the row, one column per cycle enters the shared 9-stage FMA pipe
// after a registered B store read, then the pipe drains. A row end adds the
// emission of ncols results through the output register. Reset is synchronous
// and clears control and accumulators; the B store is not cleared. A stalled
// result holds emission; no item is taken while an A element is in work.
`default_nettype none
module f32_matrix_multiply_rows import f32mm_pkg::*; #(
  parameter int MAX_K = 64,
  parameter int MAX_N = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  f32mm_in_if.sink             item,
  f32mm_out_if.source          result
);
  cmd_t cmd;
  sts_t sts;

  f32mm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  f32mm_dp #(.MAX_K(MAX_K), .MAX_N(MAX_N)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item     (item),
    .result   (result),
    .cmd      (cmd),
    .sts      (sts)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/f32mm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module f32mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/f32mm_fma.sv =====
// Nine-stage binary32 fused multiply-add pipeline with a column tag.
`default_nettype none
module f32mm_fma import f32mm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [3:0]  in_tag,
  output logic        out_valid,
  output logic [31:0] result,
  output logic [3:0]  out_tag,
  output logic        busy
);
  logic [9:1]  v;
  logic [3:0]  tg  [1:9];
  logic        spc [1:9];
  logic [31:0] spv [1:9];

  // stage 1 inputs
  logic        sa, sb, sc, sp;
  logic [7:0]  ea, eb, ec, eax, ebx, ecx;
  logic [22:0] fa, fb, fc;
  logic        za, zb, zc, nan_in, spec;
  logic [31:0] spec_v;
  logic [23:0] ma, mb;

  // stage registers
  logic [47:0] p1, p2;
  logic [23:0] cm1, cm2;
  logic signed [11:0] pe1, ce1, pe2, ce2, pe3, ce3;
  logic        sp1, sc1, zc1, sp2, sc2, zc2, sp3, sc3, zc3;
  logic [5:0]  shp2, shc2;
  logic [63:0] pn3, cn3;
  logic [63:0] big4, small4;
  logic signed [11:0] e4;
  logic        bs4, ss4;
  logic [63:0] s5, s6, n7;
  logic signed [11:0] e5, ex6, be7, be8;
  logic        sg5, sg6, sg7, sg8;
  logic [5:0]  l6, d7;
  logic        z6, z7, z8, ovf7, ovf8;
  logic [24:0] q8;

  // stage combinational
  logic [63:0] big_c, small_c, sm_c, sum_c, m_c;
  logic signed [11:0] e_c, diff_c, be_c, dd_c;
  logic        bs_c, ss_c, rup_c;
  logic [31:0] bits_c;

  assign sa = a[31];
  assign sb = b[31];
  assign sc = c[31];
  assign sp = sa ^ sb;
  assign ea = a[30:23];
  assign eb = b[30:23];
  assign ec = c[30:23];
  assign fa = a[22:0];
  assign fb = b[22:0];
  assign fc = c[22:0];
  assign za = (ea == 8'd0) && (fa == 23'd0);
  assign zb = (eb == 8'd0) && (fb == 23'd0);
  assign zc = (ec == 8'd0) && (fc == 23'd0);
  assign nan_in = ((ea == 8'hFF) && (fa != 23'd0)) || ((eb == 8'hFF) && (fb != 23'd0)) ||
                  ((ec == 8'hFF) && (fc != 23'd0));
  assign eax = (ea == 8'd0) ? 8'd1 : ea;
  assign ebx = (eb == 8'd0) ? 8'd1 : eb;
  assign ecx = (ec == 8'd0) ? 8'd1 : ec;
  assign ma = {(ea != 8'd0), fa};
  assign mb = {(eb != 8'd0), fb};

  always_comb begin
    spec   = 1'b1;
    spec_v = QNAN32;
    if (nan_in) begin
      spec_v = QNAN32;
    end else if ((ea == 8'hFF) || (eb == 8'hFF)) begin
      if (za || zb) begin
        spec_v = QNAN32;
      end else if ((ec == 8'hFF) && (sc != sp)) begin
        spec_v = QNAN32;
      end else begin
        spec_v = {sp, INF32[30:0]};
      end
    end else if (ec == 8'hFF) begin
      spec_v = c;
    end else if (za || zb) begin
      spec_v = zc ? {sp & sc, 31'd0} : c;
    end else begin
      spec = 1'b0;
    end
  end

  // stage 4: order and align
  always_comb begin
    if (zc3 || (pe3 >= ce3)) begin
      big_c   = pn3;
      e_c     = pe3;
      bs_c    = sp3;
      small_c = zc3 ? 64'd0 : cn3;
      ss_c    = sc3;
      diff_c  = zc3 ? 12'sd0 : pe3 - ce3;
    end else begin
      big_c   = cn3;
      e_c     = ce3;
      bs_c    = sc3;
      small_c = pn3;
      ss_c    = sp3;
      diff_c  = ce3 - pe3;
    end
    if (diff_c >= 12'sd63) begin
      sm_c = {63'd0, (small_c != 64'd0)};
    end else begin
      sm_c = (small_c >> diff_c[5:0]) |
             {63'd0, ((small_c & ~({64{1'b1}} << diff_c[5:0])) != 64'd0)};
    end
  end

  // stage 5: add or subtract magnitudes
  always_comb begin
    if (bs4 == ss4) begin
      sum_c = big4 + small4;
    end else if (big4 >= small4) begin
      sum_c = big4 - small4;
    end else begin
      sum_c = small4 - big4;
    end
  end

  // stage 7: exponent of the lead bit and subnormal shift
  always_comb begin
    be_c = ex6 + 12'sd127;
    dd_c = 12'sd1 - be_c;
  end

  // stage 8: denormalize with sticky, then round to nearest even
  always_comb begin
    m_c   = (n7 >> d7) | {63'd0, ((n7 & ~({64{1'b1}} << d7)) != 64'd0)};
    rup_c = m_c[39] & ((m_c[38:0] != 39'd0) | m_c[40]);
  end

  // stage 9: pack
  always_comb begin
    if (be8 >= 12'sd1) begin
      bits_c = (32'($unsigned(be8 - 12'sd1)) << 23) + 32'(q8);
    end else begin
      bits_c = 32'(q8);
    end
    if (bits_c >= INF32) begin
      bits_c = INF32;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tg[1]  <= in_tag;
    spc[1] <= spec;
    spv[1] <= spec_v;
    for (int i = 2; i <= 9; i++) begin
      tg[i]  <= tg[i-1];
      spc[i] <= spc[i-1];
      spv[i] <= spv[i-1];
    end
    // 1: unpack and multiply
    p1  <= {24'd0, ma} * {24'd0, mb};
    pe1 <= $signed({4'd0, eax}) + $signed({4'd0, ebx}) - 12'sd300;
    cm1 <= {(ec != 8'd0), fc};
    ce1 <= $signed({4'd0, ecx}) - 12'sd150;
    sp1 <= sp;
    sc1 <= sc;
    zc1 <= zc;
    // 2: lead bit search
    p2   <= p1;
    cm2  <= cm1;
    pe2  <= pe1;
    ce2  <= ce1;
    sp2  <= sp1;
    sc2  <= sc1;
    zc2  <= zc1;
    shp2 <= 6'd61 - lead64({16'd0, p1});
    shc2 <= 6'd61 - lead64({40'd0, cm1});
    // 3: normalize both operands to bit 61
    pn3 <= {16'd0, p2} << shp2;
    cn3 <= {40'd0, cm2} << shc2;
    pe3 <= pe2 - $signed({6'd0, shp2});
    ce3 <= ce2 - $signed({6'd0, shc2});
    sp3 <= sp2;
    sc3 <= sc2;
    zc3 <= zc2;
    // 4
    big4   <= big_c;
    small4 <= sm_c;
    e4     <= e_c;
    bs4    <= bs_c;
    ss4    <= ss_c;
    // 5
    s5  <= sum_c;
    e5  <= e4;
    sg5 <= (bs4 == ss4) ? bs4 : ((big4 >= small4) ? bs4 : ss4);
    // 6: lead bit of the sum
    s6  <= s5;
    l6  <= lead64(s5);
    ex6 <= e5 + $signed({6'd0, lead64(s5)});
    z6  <= (s5 == 64'd0);
    sg6 <= sg5;
    // 7
    n7   <= s6 << (6'd63 - l6);
    be7  <= be_c;
    ovf7 <= (be_c >= 12'sd255);
    d7   <= (be_c >= 12'sd1) ? 6'd0 : ((dd_c >= 12'sd63) ? 6'd63 : dd_c[5:0]);
    z7   <= z6;
    sg7  <= sg6;
    // 8
    q8   <= {1'b0, m_c[63:40]} + {24'd0, rup_c};
    be8  <= be7;
    ovf8 <= ovf7;
    z8   <= z7;
    sg8  <= sg7;
    // 9
    if (spc[8]) begin
      result <= spv[8];
    end else if (ovf8) begin
      result <= {sg8, INF32[30:0]};
    end else if (z8) begin
      result <= 32'd0;
    end else begin
      result <= {sg8, bits_c[30:0]};
    end
  end

  assign out_valid = v[9];
  assign out_tag   = tg[9];
  assign busy      = |v;
endmodule
`default_nettype wire

// ===== hw/rtl/f32mm_ctrl.sv =====
// Controller: sequences accept, column issue, drain and row emission.
`default_nettype none
module f32mm_ctrl import f32mm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.item_valid && sts.a_hit) begin
          cmd.start  = 1'b1;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = sts.row_end ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/f32mm_dp.sv =====
// Datapath: config registers, B store, accumulators, FMA pipe, output register.
`default_nettype none
module f32mm_dp import f32mm_pkg::*; #(
  parameter int MAX_K = 64,
  parameter int MAX_N = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  f32mm_in_if.sink             item,
  f32mm_out_if.source          result,
  input  cmd_t                 cmd,
  output sts_t                 sts
);
  localparam int DEPTH = MAX_K * MAX_N;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NCOL  = (MAX_N < NACC) ? MAX_N : NACC;

  logic [6:0]  inner_len;
  logic [4:0]  out_cols;
  logic [10:0] klen;
  logic [4:0]  ncols;

  logic        accept, load_ok, ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] rdata;

  logic [31:0] a_r;
  logic [5:0]  kk_r;
  logic        row_end_r;
  logic [3:0]  j, e, r_col;
  logic        r_valid;

  logic [31:0] acc [NACC];

  logic        f_valid, f_busy;
  logic [31:0] f_res;
  logic [3:0]  f_tag;

  logic        o_valid, o_last;
  logic [3:0]  o_col;
  logic [31:0] o_bits;

  always_comb begin
    if (inner_len == 7'd0) begin
      klen = 11'd1;
    end else if (11'(inner_len) > 11'(MAX_K)) begin
      klen = 11'(MAX_K);
    end else begin
      klen = 11'(inner_len);
    end
    if (out_cols == 5'd0) begin
      ncols = 5'd1;
    end else if (out_cols > 5'(NCOL)) begin
      ncols = 5'(NCOL);
    end else begin
      ncols = out_cols;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_len <= INNER_LEN_RST;
      out_cols  <= OUT_COLS_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_INNER_LEN) begin
        inner_len <= cfg_data;
      end else begin
        out_cols <= cfg_data[4:0];
      end
    end
  end

  assign item.ready = cmd.take;
  assign accept     = item.valid && cmd.take;
  assign load_ok    = (11'(item.k_index) < 11'(MAX_K)) && (7'(item.col_index) < 7'(MAX_N));
  assign ram_we     = accept && (item.opcode == OP_LOAD) && load_ok;
  assign waddr      = AW'(32'(item.k_index) * MAX_N + 32'(item.col_index));
  assign raddr      = AW'(32'(kk_r) * MAX_N + 32'(j));

  f32mm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_bstore (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (item.elem_bits),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r       <= item.elem_bits;
      kk_r      <= item.k_index;
      row_end_r <= (11'(item.k_index) == klen - 11'd1);
    end
    r_col <= j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j       <= '0;
      e       <= '0;
      r_valid <= 1'b0;
    end else begin
      r_valid <= cmd.issue;
      if (cmd.start) begin
        j <= '0;
        e <= '0;
      end else begin
        if (cmd.issue) j <= j + 4'd1;
        if (cmd.emit)  e <= e + 4'd1;
      end
    end
  end

  f32mm_fma u_fma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .a         (a_r),
    .b         (rdata),
    .c         (acc[r_col]),
    .in_tag    (r_col),
    .out_valid (f_valid),
    .result    (f_res),
    .out_tag   (f_tag),
    .busy      (f_busy)
  );

  // emission shifts the accumulators toward entry 0
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < NACC; i++) acc[i] <= 32'd0;
    end else if (cmd.emit) begin
      for (int i = 0; i < NACC - 1; i++) acc[i] <= acc[i+1];
      acc[NACC-1] <= 32'd0;
    end else if (f_valid) begin
      acc[f_tag] <= f_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.emit) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_col  <= e;
      o_bits <= acc[0];
      o_last <= (5'(e) == ncols - 5'd1);
    end
  end

  assign result.valid        = o_valid;
  assign result.out_col      = o_col;
  assign result.product_bits = o_bits;
  assign result.row_last     = o_last;

  always_comb begin
    sts.item_valid = item.valid;
    sts.a_hit      = (item.opcode == OP_A) && (11'(item.k_index) < klen);
    sts.issue_last = (5'(j) == ncols - 5'd1);
    sts.row_end    = row_end_r;
    sts.pipe_busy  = r_valid || f_busy;
    sts.out_free   = !o_valid || result.ready;
    sts.emit_last  = (5'(e) == ncols - 5'd1);
  end
endmodule
`default_nettype wire

// ===== hw/rtl/f32mm_checker.sv =====
// Port-level assertions for the row matrix multiplier, bound to the top level.
`default_nettype none
module f32mm_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [3:0]  res_col,
  input logic [31:0] res_bits,
  input logic        res_last
);
  logic res_xfer;
  assign res_xfer = res_valid && res_ready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_bits))
    else $error("result changed while stalled");

  a_row_burst: assert property (@(posedge clk) disable iff (rst)
    res_xfer && !res_last |=> res_valid && (res_col == $past(res_col) + 4'd1))
    else $error("row emission broke its column sequence");

  a_no_take_mid_row: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !item_ready)
    else $error("item taken during row emission");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");
endmodule

bind f32_matrix_multiply_rows f32mm_checker u_f32mm_checker (
  .clk        (clk),
  .rst        (rst),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_col    (result.out_col),
  .res_bits   (result.product_bits),
  .res_last   (result.row_last)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming binary32 row matrix multiplier.
`default_nettype none
module testbench import f32mm_pkg::*; ();

  localparam int KMAX = 64;
  localparam int NMAX = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [3:0]  col;
    logic [31:0] bits;
    logic        last;
  } c_elem_t;

  typedef struct {
    logic        op;
    logic [5:0]  k;
    logic [3:0]  col;
    logic [31:0] elem;
    bit          chk;
    logic [31:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  f32mm_in_if  in_ch();
  f32mm_out_if out_ch();

  f32_matrix_multiply_rows dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .item(in_ch.sink), .result(out_ch.source)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.k_index = '0;
    in_ch.col_index = '0;
    in_ch.elem_bits = '0;
    out_ch.ready = 1'b0;
  end

  // predictor state
  logic [31:0] b_mem [KMAX*NMAX];
  bit          b_set [KMAX*NMAX];
  logic [31:0] col_acc [NMAX];
  logic [6:0]  inner_len_reg = INNER_LEN_RST;
  logic [4:0]  out_cols_reg  = OUT_COLS_RST;
  c_elem_t     c_row_q [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int rows_done = 0;
  int sender_mode = 0;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic int msb_pos(logic [63:0] v);
    int r;
    r = 0;
    for (int i = 1; i < 64; i++) if (v[i]) r = i;
    return r;
  endfunction

  function automatic logic [31:0] round_f32(logic sgn, logic [63:0] s, int e);
    int l, be, sh;
    logic [63:0] q, rem, half, bits;
    l = msb_pos(s);
    be = l + e + 127;
    sh = (be >= 1) ? l - 23 : -149 - e;
    if (be >= 255) return {sgn, INF32[30:0]};
    if (sh <= 0) q = s << (-sh);
    else if (sh > 64) q = 0;
    else if (sh == 64) q = (s > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    else begin
      rem = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      q = s >> sh;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    bits = (be >= 1) ? (64'(be - 1) << 23) + q : q;
    if (bits >= 64'(INF32)) bits = 64'(INF32);
    return {sgn, bits[30:0]};
  endfunction

  function automatic logic [31:0] fused_madd(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic sa, sb, sc, sp, bigs, smalls, sgn, za, zb, zc;
    logic [7:0] ea, eb, ec;
    logic [22:0] fa, fb, fc;
    logic [63:0] p, cm, big, sml, s;
    int pe, ce, bige, diff, sh;
    sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
    ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
    fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
    za = (ea == 0 && fa == 0); zb = (eb == 0 && fb == 0); zc = (ec == 0 && fc == 0);
    if ((ea == 255 && fa != 0) || (eb == 255 && fb != 0) || (ec == 255 && fc != 0))
      return QNAN32;
    if (ea == 255 || eb == 255) begin
      if (za || zb) return QNAN32;
      if (ec == 255 && sc != sp) return QNAN32;
      return {sp, INF32[30:0]};
    end
    if (ec == 255) return c;
    if (za || zb) begin
      if (zc) return {sp & sc, 31'b0};
      return c;
    end
    p = {40'b0, ea != 0, fa} * {40'b0, eb != 0, fb};
    pe = ((ea != 0) ? int'(ea) : 1) + ((eb != 0) ? int'(eb) : 1) - 300;
    if (zc) return round_f32(sp, p, pe);
    cm = {40'b0, ec != 0, fc};
    ce = ((ec != 0) ? int'(ec) : 1) - 150;
    sh = 61 - msb_pos(p); p = p << sh; pe = pe - sh;
    sh = 61 - msb_pos(cm); cm = cm << sh; ce = ce - sh;
    if (pe >= ce) begin
      big = p; bige = pe; bigs = sp; sml = cm; smalls = sc; diff = pe - ce;
    end else begin
      big = cm; bige = ce; bigs = sc; sml = p; smalls = sp; diff = ce - pe;
    end
    if (diff >= 63) sml = (sml != 0) ? 64'd1 : 64'd0;
    else if (diff > 0)
      sml = (sml >> diff) | (((sml & ((64'd1 << diff) - 64'd1)) != 0) ? 64'd1 : 64'd0);
    if (bigs == smalls) begin
      s = big + sml; sgn = bigs;
    end else if (big >= sml) begin
      s = big - sml; sgn = bigs;
    end else begin
      s = sml - big; sgn = smalls;
    end
    if (s == 0) return 32'h0;
    return round_f32(sgn, s, bige);
  endfunction

  function automatic int eff_inner();
    if (inner_len_reg < 1) return 1;
    if (inner_len_reg > KMAX) return KMAX;
    return int'(inner_len_reg);
  endfunction

  function automatic int eff_cols();
    if (out_cols_reg < 1) return 1;
    if (out_cols_reg > NMAX) return NMAX;
    return int'(out_cols_reg);
  endfunction

  function automatic void model_item(logic op, logic [5:0] k, logic [3:0] col, logic [31:0] e);
    int klen, ncols;
    c_elem_t r;
    if (op == OP_LOAD) begin
      b_mem[k*NMAX + col] = e;
      b_set[k*NMAX + col] = 1'b1;
      return;
    end
    klen = eff_inner();
    ncols = eff_cols();
    if (k >= klen) return;
    for (int j = 0; j < ncols; j++) col_acc[j] = fused_madd(e, b_mem[k*NMAX + j], col_acc[j]);
    if (k != klen - 1) return;
    for (int j = 0; j < ncols; j++) begin
      r.col = 4'(j); r.bits = col_acc[j]; r.last = (j == ncols - 1);
      c_row_q.push_back(r);
    end
    for (int j = 0; j < NMAX; j++) col_acc[j] = 32'h0;
    rows_done++;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: stall policy, long hold-off, checker and watchdog
  always @(posedge clk) begin
    c_elem_t w;
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (sender_mode >= 2)
      out_ch.ready <= ($urandom_range(99) >= ((sender_mode == 3) ? 7 : 77));
    else out_ch.ready <= 1'b1;

    if (out_ch.valid && out_ch.ready && !rst) begin
      results_seen++;
      if (c_row_q.size() == 0) report_mismatch("unexpected result", out_ch.product_bits, 0);
      else begin
        w = c_row_q.pop_front();
        if (out_ch.out_col !== w.col) report_mismatch("out_col", out_ch.out_col, w.col);
        if (out_ch.product_bits !== w.bits)
          report_mismatch("product_bits", out_ch.product_bits, w.bits);
        if (out_ch.row_last !== w.last) report_mismatch("row_last", out_ch.row_last, w.last);
      end
    end

    if (rst || (out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", c_row_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [5:0] k, logic [3:0] col, logic [31:0] e);
    while ((sender_mode == 1 || sender_mode == 3) &&
           $urandom_range(99) < ((sender_mode == 3) ? 7 : 77)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.k_index <= k;
    in_ch.col_index <= col;
    in_ch.elem_bits <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model_item(op, k, col, e);
    items_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    wait (c_row_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INNER_LEN) inner_len_reg = val;
    else out_cols_reg = val[4:0];
  endtask

  function automatic logic [31:0] rand_f32();
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h807F_FFFF};
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return specials[$urandom_range(7)];
    if (pick < 20) return $urandom;
    return {1'($urandom), 8'($urandom_range(134, 118)), 23'($urandom)};
  endfunction

  task automatic ensure_b_row(int k);
    for (int j = 0; j < eff_cols(); j++)
      if (!b_set[k*NMAX + j]) send_item(OP_LOAD, 6'(k), 4'(j), rand_f32());
  endtask

  task automatic send_row();
    int klen, k, n;
    klen = eff_inner();
    n = (klen > 1) ? $urandom_range(3) : 0;
    repeat (n) begin
      k = $urandom_range(klen - 2);
      ensure_b_row(k);
      send_item(OP_A, 6'(k), 4'($urandom), rand_f32());
    end
    if ($urandom_range(3) == 0) begin
      k = $urandom_range(klen - 1);
      send_item(OP_LOAD, 6'(k), 4'($urandom_range(eff_cols() - 1)), rand_f32());
    end
    ensure_b_row(klen - 1);
    send_item(OP_A, 6'(klen - 1), 4'($urandom), rand_f32());
  endtask

  task automatic random_phase(int quota);
    int start, r;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(99);
      if (r < 80) send_row();
      else if (r < 90 || eff_inner() == KMAX)
        send_item(OP_LOAD, 6'($urandom), 4'($urandom), rand_f32());
      else begin
        send_item(OP_A, 6'($urandom_range(KMAX - 1, eff_inner())), 4'($urandom), $urandom);
      end
    end
  endtask

  stim_row_t plan [$];
  logic [6:0] inner_set [8] = '{7'd1, 7'd0, 7'd127, 7'd3, 7'd2, 7'd64, 7'd5, 7'd16};
  logic [6:0] cols_set  [8] = '{7'd16, 7'd0, 7'd2, 7'd31, 7'd1, 7'd7, 7'd16, 7'd4};

  initial begin
    for (int i = 0; i < KMAX*NMAX; i++) begin
      b_mem[i] = 32'h0;
      b_set[i] = 1'b0;
    end
    for (int i = 0; i < NMAX; i++) col_acc[i] = 32'h0;

    plan = '{
      '{OP_LOAD, 6'd0,  4'd0,  32'h3F80_0000, 1'b0, 32'h0},
      '{OP_A,    6'd0,  4'd0,  32'h4000_0000, 1'b1, 32'h4000_0000},
      '{OP_LOAD, 6'd0,  4'd0,  32'h7F80_0000, 1'b0, 32'h0},
      '{OP_A,    6'd0,  4'd15, 32'h0000_0000, 1'b1, QNAN32},
      '{OP_A,    6'd0,  4'd0,  32'h3F80_0000, 1'b1, INF32},
      '{OP_LOAD, 6'd0,  4'd0,  32'h7F7F_FFFF, 1'b0, 32'h0},
      '{OP_A,    6'd0,  4'd0,  32'h7F7F_FFFF, 1'b1, INF32},
      '{OP_A,    6'd0,  4'd0,  32'hFF7F_FFFF, 1'b1, 32'hFF80_0000},
      '{OP_LOAD, 6'd0,  4'd0,  32'h0000_0001, 1'b0, 32'h0},
      '{OP_A,    6'd0,  4'd0,  32'h3F80_0000, 1'b1, 32'h0000_0001},
      '{OP_A,    6'd0,  4'd0,  32'h3F00_0000, 1'b1, 32'h0000_0000},
      '{OP_A,    6'd0,  4'd0,  32'hFFFF_FFFF, 1'b1, QNAN32},
      '{OP_LOAD, 6'd0,  4'd0,  32'h8000_0000, 1'b0, 32'h0},
      '{OP_A,    6'd0,  4'd0,  32'h3F80_0000, 1'b1, 32'h0000_0000},
      '{OP_A,    6'd63, 4'd0,  32'h3F80_0000, 1'b0, 32'h0},
      '{OP_LOAD, 6'd63, 4'd15, 32'hFFFF_FFFF, 1'b0, 32'h0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(CFG_INNER_LEN, 7'd1);
    write_reg(CFG_OUT_COLS, 7'd1);
    foreach (plan[i]) begin
      send_item(plan[i].op, plan[i].k, plan[i].col, plan[i].elem);
      if (plan[i].chk && c_row_q.size() != 0 && c_row_q[$].bits !== plan[i].want)
        report_mismatch("directed prediction", c_row_q[$].bits, plan[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_INNER_LEN, inner_set[ph]);
      write_reg(CFG_OUT_COLS, cols_set[ph]);
      sender_mode = ph % 4;
      if (ph == 0) hold_seq++;
      random_phase(52);
    end

    settle();
    $display("covered %0d items, %0d rows, %0d result elements checked",
             items_sent, rows_done, results_seen);
    $display("config sweep: inner length 1..64 incl. saturation, 1..16 output columns");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== f32_matrix_multiply_rows.f =====
hw/rtl/f32mm_pkg.sv
hw/rtl/f32mm_if.sv
hw/rtl/f32mm_ram.sv
hw/rtl/f32mm_fma.sv
hw/rtl/f32mm_ctrl.sv
hw/rtl/f32mm_dp.sv
hw/rtl/f32_matrix_multiply_rows.sv
hw/rtl/f32mm_checker.sv
tb/testbench.sv
